/* hdl/signed_integer_to_radix_text_macros.svh */
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text_macros.svh
// Assertion helpers for the radix text converter: clocked implication
// checks that are disabled while reset is applied.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INTEGER_TO_RADIX_TEXT_MACROS_SVH
`define SIGNED_INTEGER_TO_RADIX_TEXT_MACROS_SVH

// same-cycle implication
`define SITRT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SITRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/sitrt_pkg.sv */
// ----------------------------------------------------------------------------
// sitrt_pkg
// Shared constants, types, microcode program and symbol lookup for the
// signed integer to radix text converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sitrt_pkg;

	// widths
	localparam int VALUE_BITS    = 32;
	localparam int MAX_SYMBOLS   = 16;
	localparam int SYM_W         = 8;
	localparam int TABLE_W       = MAX_SYMBOLS * SYM_W;
	localparam int DIGIT_W       = $clog2(MAX_SYMBOLS);
	localparam int RADIX_W       = $clog2(MAX_SYMBOLS + 1);
	localparam int ADDR_W        = $clog2(VALUE_BITS);
	localparam int CNT_W         = $clog2(VALUE_BITS + 1);
	localparam int BITS_PER_STEP = 8;
	localparam int DIV_STEPS     = VALUE_BITS / BITS_PER_STEP;
	localparam int DIV_CNT_W     = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 64;
	localparam int COUNT_REG_W   = 5;
	localparam int PC_W          = 3;

	// characters
	localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [SYM_W-1:0] CHAR_NUL   = 8'h00;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

	// register reset values: radix ten, "0123456789"
	localparam logic [COUNT_REG_W-1:0] RST_SYMBOL_COUNT = 5'd10;
	localparam logic [CFG_DATA_W-1:0]  RST_SYMBOLS_LOW  = 64'h3736_3534_3332_3130;
	localparam logic [CFG_DATA_W-1:0]  RST_SYMBOLS_HIGH = 64'h0000_0000_0000_3938;

	// program addresses
	localparam logic [PC_W-1:0] PC_IDLE  = 3'd0;
	localparam logic [PC_W-1:0] PC_CHECK = 3'd1;
	localparam logic [PC_W-1:0] PC_DIV   = 3'd2;
	localparam logic [PC_W-1:0] PC_STORE = 3'd3;
	localparam logic [PC_W-1:0] PC_SIGN  = 3'd4;
	localparam logic [PC_W-1:0] PC_READ  = 3'd5;
	localparam logic [PC_W-1:0] PC_EMIT  = 3'd6;
	localparam logic [PC_W-1:0] PC_TAIL  = 3'd7;

	// datapath operations
	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_CLEAR,
		OP_DIV,
		OP_STORE,
		OP_SIGN,
		OP_READ,
		OP_EMIT
	} dp_op_t;

	// jump conditions
	typedef enum logic [2:0] {
		JC_NONE,
		JC_ALWAYS,
		JC_NO_START,
		JC_TABLE_BAD,
		JC_DIV_MORE,
		JC_QUOT_NZ,
		JC_CNT_MORE
	} jcond_t;

	typedef struct packed {
		dp_op_t          op;
		jcond_t          cond;
		logic [PC_W-1:0] target;
	} ucode_t;

	// datapath flags seen by the sequencer
	typedef struct packed {
		logic start;
		logic table_bad;
		logic div_more;
		logic quot_nz;
		logic cnt_more;
	} status_t;

	// checked symbol table
	typedef struct packed {
		logic               ok;
		logic [RADIX_W-1:0] radix;
		logic [TABLE_W-1:0] symbols;
	} table_t;

	// control store
	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		case (pc)
			PC_IDLE:  w = '{op: OP_LOAD,  cond: JC_NO_START,  target: PC_IDLE};
			PC_CHECK: w = '{op: OP_CLEAR, cond: JC_TABLE_BAD, target: PC_IDLE};
			PC_DIV:   w = '{op: OP_DIV,   cond: JC_DIV_MORE,  target: PC_DIV};
			PC_STORE: w = '{op: OP_STORE, cond: JC_QUOT_NZ,   target: PC_DIV};
			PC_SIGN:  w = '{op: OP_SIGN,  cond: JC_NONE,      target: PC_IDLE};
			PC_READ:  w = '{op: OP_READ,  cond: JC_NONE,      target: PC_IDLE};
			PC_EMIT:  w = '{op: OP_EMIT,  cond: JC_CNT_MORE,  target: PC_READ};
			PC_TAIL:  w = '{op: OP_NOP,   cond: JC_ALWAYS,    target: PC_IDLE};
			default:  w = '{op: OP_NOP,   cond: JC_ALWAYS,    target: PC_IDLE};
		endcase
		return w;
	endfunction

	// byte of symbol idx
	function automatic logic [SYM_W-1:0] sym_byte(input logic [TABLE_W-1:0] tbl,
			input logic [DIGIT_W-1:0] idx);
		return tbl[idx*SYM_W +: SYM_W];
	endfunction

endpackage

/* hdl/sitrt_cfg_regs.sv */
// ----------------------------------------------------------------------------
// sitrt_cfg_regs
// Configuration registers and symbol table check: radix, sign symbols and
// duplicates, registered for the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sitrt_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [sitrt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sitrt_pkg::CFG_DATA_W-1:0] cfg_data,
	output sitrt_pkg::table_t                tbl
);
	import sitrt_pkg::*;

	logic [COUNT_REG_W-1:0] symbol_count_q;
	logic [CFG_DATA_W-1:0]  symbols_low_q;
	logic [CFG_DATA_W-1:0]  symbols_high_q;
	logic [TABLE_W-1:0]     symbols;
	logic [RADIX_W-1:0]     limit;
	logic [MAX_SYMBOLS-1:0] nz;
	logic [MAX_SYMBOLS-1:0] present;
	logic [RADIX_W-1:0]     n;
	logic                   bad;
	logic                   ok_q;
	logic [RADIX_W-1:0]     radix_q;

	assign symbols = {symbols_high_q, symbols_low_q};

	// register writes; unknown index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbol_count_q <= RST_SYMBOL_COUNT;
			symbols_low_q  <= RST_SYMBOLS_LOW;
			symbols_high_q <= RST_SYMBOLS_HIGH;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SYMBOL_COUNT: symbol_count_q <= cfg_data[COUNT_REG_W-1:0];
				REG_SYMBOLS_LOW:  symbols_low_q  <= cfg_data;
				REG_SYMBOLS_HIGH: symbols_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// count saturates at the table size
	assign limit = (symbol_count_q > COUNT_REG_W'(MAX_SYMBOLS)) ?
		RADIX_W'(MAX_SYMBOLS) : RADIX_W'(symbol_count_q);

	// symbols in use: under the limit and before the first zero byte
	always_comb begin
		for (int i = 0; i < MAX_SYMBOLS; i++) begin
			nz[i] = symbols[i*SYM_W +: SYM_W] != CHAR_NUL;
		end
		for (int i = 0; i < MAX_SYMBOLS; i++) begin
			present[i] = (RADIX_W'(i) < limit);
			for (int j = 0; j <= i; j++) begin
				present[i] = present[i] & nz[j];
			end
		end
	end

	// radix is the length of the prefix
	always_comb begin
		n = '0;
		for (int i = 0; i < MAX_SYMBOLS; i++) begin
			n = n + RADIX_W'(present[i]);
		end
	end

	// sign characters and repeated bytes
	always_comb begin
		bad = 1'b0;
		for (int i = 0; i < MAX_SYMBOLS; i++) begin
			if (present[i] && (symbols[i*SYM_W +: SYM_W] == CHAR_PLUS ||
					symbols[i*SYM_W +: SYM_W] == CHAR_MINUS)) begin
				bad = 1'b1;
			end
			for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
				if (present[i] && present[j] &&
						symbols[i*SYM_W +: SYM_W] == symbols[j*SYM_W +: SYM_W]) begin
					bad = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q    <= 1'b0;
			radix_q <= '0;
		end else begin
			ok_q    <= (n >= RADIX_W'(2)) && !bad;
			radix_q <= n;
		end
	end

	assign tbl = '{ok: ok_q, radix: radix_q, symbols: symbols};

endmodule

/* hdl/sitrt_sequencer.sv */
// ----------------------------------------------------------------------------
// sitrt_sequencer
// Program counter over the control store; picks the next step from the
// jump condition of the current control word and the datapath flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sitrt_sequencer (
	input  logic               clk,
	input  logic               arst_n,
	input  sitrt_pkg::status_t status,
	output sitrt_pkg::dp_op_t  op,
	output logic               busy
);
	import sitrt_pkg::*;

	logic [PC_W-1:0] pc_q;
	ucode_t          uw;
	logic            take;

	assign uw = ucode_rom(pc_q);

	// jump condition select
	always_comb begin
		case (uw.cond)
			JC_NONE:      take = 1'b0;
			JC_ALWAYS:    take = 1'b1;
			JC_NO_START:  take = !status.start;
			JC_TABLE_BAD: take = status.table_bad;
			JC_DIV_MORE:  take = status.div_more;
			JC_QUOT_NZ:   take = status.quot_nz;
			JC_CNT_MORE:  take = status.cnt_more;
			default:      take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else begin
			pc_q <= take ? uw.target : pc_q + PC_W'(1);
		end
	end

	assign op   = uw.op;
	assign busy = pc_q != PC_IDLE;

endmodule

/* hdl/sitrt_datapath.sv */
// ----------------------------------------------------------------------------
// sitrt_datapath
// Magnitude register with a multi-bit restoring divider, digit buffer,
// and the output register for characters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sitrt_datapath (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  sitrt_pkg::dp_op_t                       op,
	input  logic                                    start,
	input  logic signed [sitrt_pkg::VALUE_BITS-1:0] value,
	input  sitrt_pkg::table_t                       tbl,
	output sitrt_pkg::status_t                      status,
	output logic                                    result_valid,
	output logic [sitrt_pkg::SYM_W-1:0]             char_code,
	output logic                                    last
);
	import sitrt_pkg::*;

	logic [VALUE_BITS-1:0] mag_q;
	logic [DIGIT_W-1:0]    rem_q;
	logic                  neg_q;
	logic [CNT_W-1:0]      count_q;
	logic [DIV_CNT_W-1:0]  bitcnt_q;
	logic [DIGIT_W-1:0]    mem [VALUE_BITS];
	logic [DIGIT_W-1:0]    rd_q;
	logic                  result_valid_q;
	logic [SYM_W-1:0]      char_q;
	logic                  last_q;
	logic [VALUE_BITS-1:0] value_u;
	logic [VALUE_BITS-1:0] div_m;
	logic [DIGIT_W-1:0]    div_r;
	logic [DIGIT_W:0]      div_t;
	logic [ADDR_W-1:0]     rd_addr;

	assign value_u = unsigned'(value);
	assign rd_addr = ADDR_W'(count_q - CNT_W'(1));

	// several quotient bits per cycle; remainder stays below the radix
	always_comb begin
		div_r = rem_q;
		div_m = mag_q;
		div_t = '0;
		for (int k = 0; k < BITS_PER_STEP; k++) begin
			div_t = {div_r, div_m[VALUE_BITS-1]};
			div_m = {div_m[VALUE_BITS-2:0], 1'b0};
			if (div_t >= (DIGIT_W+1)'(tbl.radix)) begin
				div_r    = DIGIT_W'(div_t - (DIGIT_W+1)'(tbl.radix));
				div_m[0] = 1'b1;
			end else begin
				div_r = div_t[DIGIT_W-1:0];
			end
		end
	end

	// counters and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			bitcnt_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= (op == OP_EMIT) || (op == OP_SIGN && neg_q);
			case (op)
				OP_CLEAR: begin
					count_q  <= '0;
					bitcnt_q <= '0;
				end
				OP_DIV:   bitcnt_q <= bitcnt_q + DIV_CNT_W'(1);
				OP_STORE: count_q <= count_q + CNT_W'(1);
				OP_EMIT:  count_q <= count_q - CNT_W'(1);
				default: ;
			endcase
		end
	end

	// magnitude, remainder and output payload
	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				neg_q <= value_u[VALUE_BITS-1];
				mag_q <= value_u[VALUE_BITS-1] ? (~value_u + VALUE_BITS'(1)) : value_u;
			end
			OP_CLEAR: rem_q <= '0;
			OP_DIV: begin
				mag_q <= div_m;
				rem_q <= div_r;
			end
			OP_STORE: rem_q <= '0;
			default: ;
		endcase
		char_q <= (op == OP_SIGN) ? CHAR_MINUS : sym_byte(tbl.symbols, rd_q);
		last_q <= (op == OP_EMIT) && (count_q == CNT_W'(1));
	end

	// digit buffer, least significant digit at address zero
	always_ff @(posedge clk) begin
		if (op == OP_STORE) begin
			mem[count_q[ADDR_W-1:0]] <= rem_q;
		end
		if (op == OP_READ) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign status = '{
		start:     start,
		table_bad: !tbl.ok,
		div_more:  bitcnt_q != DIV_CNT_W'(DIV_STEPS - 1),
		quot_nz:   mag_q != '0,
		cnt_more:  count_q != CNT_W'(1)
	};

	assign result_valid = result_valid_q;
	assign char_code    = char_q;
	assign last         = last_q;

endmodule

/* hdl/signed_integer_to_radix_text.sv */
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text
// Converts a signed 32-bit value to text in the radix of a configured
// symbol table, one character per beat, most significant digit first.
// ----------------------------------------------------------------------------
//  channel   | direction | signals
//  ----------+-----------+--------------------------------------------------
//  command   | in        | start, busy, value
//  result    | out       | result_valid, char_code, last
//  config    | in        | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// A value is taken when start is high and busy low. Each digit takes
// divider steps of eight quotient bits each plus a buffer write, and
// each character a buffer read plus an output step. An invalid table
// ends the command at the table check with no beats.
// Reset is asynchronous; the table returns to decimal "0123456789".
// Result beats are one cycle wide and are never held back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "signed_integer_to_radix_text_macros.svh"

module signed_integer_to_radix_text (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic signed [sitrt_pkg::VALUE_BITS-1:0] value,
	output logic                                    result_valid,
	output logic [sitrt_pkg::SYM_W-1:0]             char_code,
	output logic                                    last,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [sitrt_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [sitrt_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import sitrt_pkg::*;

	table_t  tbl;
	status_t status;
	dp_op_t  op;

	assign cfg_ready = 1'b1;

	sitrt_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tbl       (tbl)
	);

	sitrt_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.op     (op),
		.busy   (busy)
	);

	sitrt_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.start        (start),
		.value        (value),
		.tbl          (tbl),
		.status       (status),
		.result_valid (result_valid),
		.char_code    (char_code),
		.last         (last)
	);

	// checks
	`SITRT_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "command not taken")
	`SITRT_ASSERT_NOW(a_beat_in_cmd, clk, arst_n, result_valid, $past(busy), "beat while idle")
	`SITRT_ASSERT_NEXT(a_last_ends, clk, arst_n, result_valid && last, !busy, "busy after last beat")

endmodule
